>>> design/css_pkg.sv
// Shared types and constants for the crossing stop sequencer.
`timescale 1ns / 1ps

package css_pkg;

    localparam int TIME_BITS     = 48;
    localparam int FIELD_TIME_W  = 48;
    localparam int CFG_W         = 32;
    localparam int ADDR_W        = 3;
    localparam int IN_DATA_W     = 56;
    localparam int OUT_DATA_W    = 112;

    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [FIELD_TIME_W-1:0] field_time_t;

    localparam logic [0:0] REG_ARM_ABSENCE = 1'b0;
    localparam logic [0:0] REG_STOP_DELAY  = 1'b1;

    localparam logic [CFG_W-1:0] ARM_ABSENCE_RST = 32'd300;
    localparam logic [CFG_W-1:0] STOP_DELAY_RST  = 32'd0;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_CLEAR = 3'd1,
        PH_ARMED = 3'd2,
        PH_DELAY = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        RS_INACTIVE   = 4'd0,
        RS_WAIT_FIRST = 4'd1,
        RS_FIRST_REC  = 4'd2,
        RS_PRESENT    = 4'd3,
        RS_ARMED      = 4'd4,
        RS_ABSENCE    = 4'd5,
        RS_WAIT_RE    = 4'd6,
        RS_DELAY_DONE = 4'd7,
        RS_REENTRY    = 4'd8,
        RS_DELAY_ACT  = 4'd9,
        RS_STOP_REQ   = 4'd10
    } reason_t;

endpackage

>>> design/crossing_stop_sequencer.sv
// Crossing stop sequencer: frame report in, phase and stop decision out.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  session_active, crossing_seen, frame_time_ms
// m_*       out  m_tvalid/m_tready  phases, reason, elapsed times, stop, echoes
// APB       in   psel/penable       arm_absence_ms @0x0, stop_delay_ms @0x4
//
// One request per cycle sustained while m_tready stays high. The accepting edge
// registers the request; once the result stage has room, the advancing edge runs
// one subtract/compare per timer, loads the result register and m_tvalid, and
// updates the phase state. A stalled m_tready holds the result; s_tready drops
// only when both stages are full and m_tready is low.
// rst_n is asynchronous: phase PH_FIRST, timestamps 0, registers 300 and 0.

module crossing_stop_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] session_active, [1] crossing_seen, [49:2] frame_time_ms
    input  logic [css_pkg::IN_DATA_W-1:0]    s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] phase_before, [5:3] phase_after, [9:6] reason_code,
    // [57:10] absence_time, [105:58] delay_elapsed_ms,
    // [106] stop_request, [107] session_echo, [108] seen_echo
    output logic [css_pkg::OUT_DATA_W-1:0]   m_tdata,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [css_pkg::ADDR_W-1:0]       paddr,
    input  logic [css_pkg::CFG_W-1:0]        pwdata,
    output logic [css_pkg::CFG_W-1:0]        prdata,
    output logic                             pready
);

    logic                         cfg_wr;
    logic [css_pkg::CFG_W-1:0]    arm_absence_reg;
    logic [css_pkg::CFG_W-1:0]    stop_delay_reg;

    logic                         in_valid_reg;
    logic                         in_active_reg;
    logic                         in_seen_reg;
    css_pkg::time_t               in_time_reg;

    css_pkg::phase_t              phase_reg;
    css_pkg::phase_t              phase_next;
    css_pkg::time_t               last_seen_reg;
    css_pkg::time_t               last_seen_next;
    css_pkg::time_t               delay_start_reg;
    css_pkg::time_t               delay_start_next;

    css_pkg::reason_t             reason;
    css_pkg::time_t               absence;
    css_pkg::time_t               delay;
    css_pkg::time_t               absence_calc;
    css_pkg::time_t               delay_calc;

    logic                         out_valid_reg;
    css_pkg::phase_t              out_before_reg;
    css_pkg::phase_t              out_after_reg;
    css_pkg::reason_t             out_reason_reg;
    css_pkg::field_time_t         out_absence_reg;
    css_pkg::field_time_t         out_delay_reg;
    logic                         out_stop_reg;
    logic                         out_active_reg;
    logic                         out_seen_reg;

    logic                         advance;
    logic                         s_accept;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == css_pkg::REG_STOP_DELAY) ? stop_delay_reg : arm_absence_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_absence_reg <= css_pkg::ARM_ABSENCE_RST;
            stop_delay_reg  <= css_pkg::STOP_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == css_pkg::REG_STOP_DELAY)
                stop_delay_reg <= pwdata;
            else
                arm_absence_reg <= pwdata;
        end
    end

    // Pipeline handshake
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_active_reg <= s_tdata[0];
            in_seen_reg   <= s_tdata[1];
            in_time_reg   <= css_pkg::TIME_BITS'(s_tdata[css_pkg::FIELD_TIME_W+1:2]);
        end
    end

    // Elapsed times, clamped at zero when the timestamp runs backwards
    assign absence_calc = (in_time_reg >= last_seen_reg) ?
                          (in_time_reg - last_seen_reg) : '0;
    assign delay_calc   = (in_time_reg >= delay_start_reg) ?
                          (in_time_reg - delay_start_reg) : '0;

    always_comb
    begin
        phase_next       = phase_reg;
        last_seen_next   = last_seen_reg;
        delay_start_next = delay_start_reg;
        reason           = css_pkg::RS_INACTIVE;
        absence          = '0;
        delay            = '0;

        if (!in_active_reg)
        begin
            phase_next       = css_pkg::PH_FIRST;
            last_seen_next   = '0;
            delay_start_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                css_pkg::PH_CLEAR:
                begin
                    if (in_seen_reg)
                    begin
                        last_seen_next = in_time_reg;
                        reason         = css_pkg::RS_PRESENT;
                    end
                    else
                    begin
                        absence = absence_calc;
                        if (absence_calc >= css_pkg::TIME_BITS'(arm_absence_reg))
                        begin
                            phase_next = css_pkg::PH_ARMED;
                            reason     = css_pkg::RS_ARMED;
                        end
                        else
                            reason = css_pkg::RS_ABSENCE;
                    end
                end
                css_pkg::PH_ARMED:
                begin
                    reason = css_pkg::RS_WAIT_RE;
                    if (in_seen_reg)
                    begin
                        delay_start_next = in_time_reg;
                        if (stop_delay_reg == '0)
                        begin
                            phase_next = css_pkg::PH_STOP;
                            reason     = css_pkg::RS_DELAY_DONE;
                        end
                        else
                        begin
                            phase_next = css_pkg::PH_DELAY;
                            reason     = css_pkg::RS_REENTRY;
                        end
                    end
                end
                css_pkg::PH_DELAY:
                begin
                    delay = delay_calc;
                    if (delay_calc >= css_pkg::TIME_BITS'(stop_delay_reg))
                    begin
                        phase_next = css_pkg::PH_STOP;
                        reason     = css_pkg::RS_DELAY_DONE;
                    end
                    else
                        reason = css_pkg::RS_DELAY_ACT;
                end
                css_pkg::PH_STOP:
                    reason = css_pkg::RS_STOP_REQ;
                default:
                begin
                    phase_next = css_pkg::PH_FIRST;
                    reason     = css_pkg::RS_WAIT_FIRST;
                    if (in_seen_reg)
                    begin
                        phase_next     = css_pkg::PH_CLEAR;
                        last_seen_next = in_time_reg;
                        reason         = css_pkg::RS_FIRST_REC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= css_pkg::PH_FIRST;
            last_seen_reg   <= '0;
            delay_start_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            last_seen_reg   <= last_seen_next;
            delay_start_reg <= delay_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_before_reg  <= phase_reg;
            out_after_reg   <= phase_next;
            out_reason_reg  <= reason;
            out_absence_reg <= css_pkg::FIELD_TIME_W'(absence);
            out_delay_reg   <= css_pkg::FIELD_TIME_W'(delay);
            out_stop_reg    <= (phase_next == css_pkg::PH_STOP);
            out_active_reg  <= in_active_reg;
            out_seen_reg    <= in_seen_reg;
        end
    end

    assign m_tdata = {3'b000, out_seen_reg, out_active_reg, out_stop_reg,
                      out_delay_reg, out_absence_reg, out_reason_reg,
                      out_after_reg, out_before_reg};

    // Checks
    a_inactive_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_active_reg |=> phase_reg == css_pkg::PH_FIRST
                                      && last_seen_reg == '0 && delay_start_reg == '0)
        else $error("inactive session did not clear the phase state");

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_active_reg && phase_reg == css_pkg::PH_STOP
        |=> phase_reg == css_pkg::PH_STOP)
        else $error("stop phase left while session active");

    a_absence_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_absence_reg != '0 |-> out_before_reg == css_pkg::PH_CLEAR)
        else $error("absence time reported outside clearance phase");

    a_delay_only_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_delay_reg != '0 |-> out_before_reg == css_pkg::PH_DELAY)
        else $error("delay time reported outside delay phase");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

>>> tb/sv/crossing_stop_sequencer_tb.sv
// Self-checking testbench: directed and random frame reports checked against a local phase predictor.
`timescale 1ns / 1ps

module crossing_stop_sequencer_tb;

    typedef struct packed {
        css_pkg::field_time_t stamp;
        logic                 seen;
        logic                 active;
    } frame_t;

    typedef struct packed {
        css_pkg::phase_t      start_phase;
        css_pkg::phase_t      after;
        css_pkg::reason_t     reason;
        css_pkg::field_time_t absence;
        css_pkg::field_time_t delay;
        logic                 stop;
        logic                 sess;
        logic                 seen;
    } decision_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [css_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [css_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [css_pkg::ADDR_W-1:0]     paddr = '0;
    logic [css_pkg::CFG_W-1:0]      pwdata = '0;
    logic [css_pkg::CFG_W-1:0]      prdata;
    logic                           pready;

    frame_t      frames_pending[$];
    decision_t   decisions_due[$];
    int          frames_made = 0;
    int          fail_count = 0;
    bit          frame_taken = 1'b0;
    bit          calm = 1'b0;
    int          stalls_asked = 0;
    int          stalls_done = 0;
    int          stall_left = 0;

    // predictor state
    logic [css_pkg::CFG_W-1:0] arm_cfg = css_pkg::ARM_ABSENCE_RST;
    logic [css_pkg::CFG_W-1:0] delay_cfg = css_pkg::STOP_DELAY_RST;
    css_pkg::phase_t           held_phase = css_pkg::PH_FIRST;
    css_pkg::field_time_t      last_sighting = '0;
    css_pkg::field_time_t      delay_origin = '0;

    crossing_stop_sequencer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(3_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic css_pkg::field_time_t elapsed_ms(css_pkg::field_time_t stamp,
                                                        css_pkg::field_time_t origin);
        return (stamp >= origin) ? stamp - origin : '0;
    endfunction

    function automatic decision_t sequence_frame(frame_t f);
        decision_t d;
        d = '0;
        d.start_phase = held_phase;
        d.sess = f.active;
        d.seen = f.seen;
        if (!f.active)
        begin
            held_phase = css_pkg::PH_FIRST;
            last_sighting = '0;
            delay_origin = '0;
            d.reason = css_pkg::RS_INACTIVE;
        end
        else
        begin
            unique case (held_phase)
                css_pkg::PH_CLEAR:
                begin
                    if (f.seen)
                    begin
                        last_sighting = f.stamp;
                        d.reason = css_pkg::RS_PRESENT;
                    end
                    else
                    begin
                        d.absence = elapsed_ms(f.stamp, last_sighting);
                        if (d.absence >= css_pkg::field_time_t'(arm_cfg))
                        begin
                            held_phase = css_pkg::PH_ARMED;
                            d.reason = css_pkg::RS_ARMED;
                        end
                        else
                            d.reason = css_pkg::RS_ABSENCE;
                    end
                end
                css_pkg::PH_ARMED:
                begin
                    d.reason = css_pkg::RS_WAIT_RE;
                    if (f.seen)
                    begin
                        delay_origin = f.stamp;
                        if (delay_cfg == '0)
                        begin
                            held_phase = css_pkg::PH_STOP;
                            d.reason = css_pkg::RS_DELAY_DONE;
                        end
                        else
                        begin
                            held_phase = css_pkg::PH_DELAY;
                            d.reason = css_pkg::RS_REENTRY;
                        end
                    end
                end
                css_pkg::PH_DELAY:
                begin
                    d.delay = elapsed_ms(f.stamp, delay_origin);
                    if (d.delay >= css_pkg::field_time_t'(delay_cfg))
                    begin
                        held_phase = css_pkg::PH_STOP;
                        d.reason = css_pkg::RS_DELAY_DONE;
                    end
                    else
                        d.reason = css_pkg::RS_DELAY_ACT;
                end
                css_pkg::PH_STOP:
                    d.reason = css_pkg::RS_STOP_REQ;
                default:
                begin
                    d.reason = css_pkg::RS_WAIT_FIRST;
                    held_phase = css_pkg::PH_FIRST;
                    if (f.seen)
                    begin
                        held_phase = css_pkg::PH_CLEAR;
                        last_sighting = f.stamp;
                        d.reason = css_pkg::RS_FIRST_REC;
                    end
                end
            endcase
        end
        d.after = held_phase;
        d.stop = (held_phase == css_pkg::PH_STOP);
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        if (fail_count <= 50)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // request driver
    always @(negedge clk)
    begin
        bit offer;
        offer = 1'b0;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || frame_taken)
        begin
            offer = frames_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 35);
            if (offer)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= css_pkg::IN_DATA_W'(frames_pending.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result back-pressure, with long hold-offs on demand
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_done != stalls_asked)
        begin
            stalls_done <= stalls_done + 1;
            stall_left <= 300;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || $urandom_range(0, 99) >= 35;
    end

    // monitor
    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n)
        begin
            frame_taken = s_tvalid && s_tready;
            if (frame_taken)
                decisions_due.push_back(sequence_frame(frame_t'(s_tdata[49:0])));
            if (m_tvalid && m_tready)
            begin
                if (decisions_due.size() == 0)
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                else
                begin
                    want = decisions_due.pop_front();
                    if (m_tdata[2:0] !== want.start_phase)
                        report_mismatch("phase_before", 64'(m_tdata[2:0]),
                                        64'(want.start_phase));
                    if (m_tdata[5:3] !== want.after)
                        report_mismatch("phase_after", 64'(m_tdata[5:3]), 64'(want.after));
                    if (m_tdata[9:6] !== want.reason)
                        report_mismatch("reason_code", 64'(m_tdata[9:6]), 64'(want.reason));
                    if (m_tdata[57:10] !== want.absence)
                        report_mismatch("absence_time", 64'(m_tdata[57:10]),
                                        64'(want.absence));
                    if (m_tdata[105:58] !== want.delay)
                        report_mismatch("delay_elapsed_ms", 64'(m_tdata[105:58]),
                                        64'(want.delay));
                    if (m_tdata[106] !== want.stop)
                        report_mismatch("stop_request", 64'(m_tdata[106]), 64'(want.stop));
                    if (m_tdata[107] !== want.sess)
                        report_mismatch("session_echo", 64'(m_tdata[107]), 64'(want.sess));
                    if (m_tdata[108] !== want.seen)
                        report_mismatch("seen_echo", 64'(m_tdata[108]), 64'(want.seen));
                end
            end
        end
    end

    task automatic apb_write(logic [0:0] reg_sel, logic [css_pkg::CFG_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == css_pkg::REG_ARM_ABSENCE)
            arm_cfg = value;
        else if (reg_sel == css_pkg::REG_STOP_DELAY)
            delay_cfg = value;
    endtask

    task automatic drain();
        while (frames_pending.size() != 0 || s_tvalid || decisions_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_frame(bit active, bit seen, css_pkg::field_time_t stamp);
        frames_pending.push_back({stamp, seen, active});
        frames_made++;
    endtask

    // one session: reset, first sighting, absence, armed, re-entry, delay, stop
    task automatic push_session();
        css_pkg::field_time_t t;
        css_pkg::field_time_t seen_at;
        css_pkg::field_time_t start_at;
        int                   quit;
        int                   n;
        quit = $urandom_range(0, 9);
        t = ($urandom_range(0, 3) == 0) ? css_pkg::field_time_t'({$urandom(), $urandom()})
                                        : css_pkg::field_time_t'($urandom_range(0, 100000));
        seen_at = t;
        push_frame(1'b0, 1'($urandom_range(0, 1)),
                   css_pkg::field_time_t'({$urandom(), $urandom()}));
        repeat ($urandom_range(0, 2))
        begin
            push_frame(1'b1, 1'b0, t);
            t += css_pkg::field_time_t'($urandom_range(1, 40));
        end
        if (quit == 0)
        begin
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
            return;
        end
        repeat ($urandom_range(1, 3))
        begin
            push_frame(1'b1, 1'b1, t);
            seen_at = t;
            t += css_pkg::field_time_t'($urandom_range(1, 40));
        end
        if (quit == 1)
        begin
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
            return;
        end
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    seen_at = t;
                    push_frame(1'b1, 1'b1, t);
                end
                1:
                begin
                    t -= css_pkg::field_time_t'($urandom_range(1, 60));
                    push_frame(1'b1, 1'b0, t);
                end
                default:
                begin
                    t += css_pkg::field_time_t'(arm_cfg / (n + 1));
                    push_frame(1'b1, 1'b0, t);
                end
            endcase
        end
        t = seen_at + css_pkg::field_time_t'(arm_cfg)
            + css_pkg::field_time_t'($urandom_range(0, 1));
        push_frame(1'b1, 1'b0, t);
        if (quit == 2)
        begin
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            t += css_pkg::field_time_t'($urandom_range(1, 100));
            push_frame(1'b1, 1'b0, t);
        end
        if (quit == 3)
        begin
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
            return;
        end
        t += css_pkg::field_time_t'($urandom_range(1, 100));
        push_frame(1'b1, 1'b1, t);
        start_at = t;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                t -= css_pkg::field_time_t'($urandom_range(1, 60));
            else
                t += css_pkg::field_time_t'(delay_cfg / (n + 1));
            push_frame(1'b1, 1'($urandom_range(0, 1)), t);
        end
        if (quit == 4)
        begin
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
            return;
        end
        t = start_at + css_pkg::field_time_t'(delay_cfg)
            + css_pkg::field_time_t'($urandom_range(0, 1));
        push_frame(1'b1, 1'($urandom_range(0, 1)), t);
        repeat ($urandom_range(1, 3))
        begin
            t += css_pkg::field_time_t'($urandom_range(1, 1000));
            push_frame(1'b1, 1'($urandom_range(0, 1)), t);
        end
        if ($urandom_range(0, 7) != 0)
            push_frame(1'b0, 1'($urandom_range(0, 1)), t);
    endtask

    initial
    begin
        logic [css_pkg::CFG_W-1:0] arm_set [6];
        logic [css_pkg::CFG_W-1:0] delay_set [6];
        int                        target;
        arm_set[0] = 32'd0;
        arm_set[1] = 32'd300;
        arm_set[2] = $urandom_range(1, 2000);
        arm_set[3] = 32'hFFFF_FFFF;
        arm_set[4] = 32'd1;
        arm_set[5] = $urandom();
        delay_set[0] = 32'd0;
        delay_set[1] = $urandom_range(1, 500);
        delay_set[2] = $urandom_range(1, 2000);
        delay_set[3] = 32'hFFFF_FFFF;
        delay_set[4] = 32'd1;
        delay_set[5] = $urandom();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: immediate stop on re-entry
        push_frame(1'b0, 1'b1, 48'hFFFF_FFFF_FFFF);
        push_frame(1'b1, 1'b0, 48'd0);
        push_frame(1'b1, 1'b1, 48'd100);
        push_frame(1'b1, 1'b1, 48'd150);
        push_frame(1'b1, 1'b0, 48'd200);
        push_frame(1'b1, 1'b0, 48'd140);
        push_frame(1'b1, 1'b0, 48'd450);
        push_frame(1'b1, 1'b0, 48'd500);
        push_frame(1'b1, 1'b1, 48'd600);
        push_frame(1'b1, 1'b1, 48'd700);
        push_frame(1'b0, 1'b0, 48'd800);
        drain();

        // delayed stop near the top of the time range, with backward stamps
        apb_write(css_pkg::REG_STOP_DELAY, 32'd1000);
        @(posedge clk);
        push_frame(1'b1, 1'b1, 48'hFFFF_FFFF_F000);
        push_frame(1'b1, 1'b0, 48'hFFFF_FFFF_F0FF);
        push_frame(1'b1, 1'b0, 48'h0000_0000_0100);
        push_frame(1'b1, 1'b0, 48'hFFFF_FFFF_F12C);
        push_frame(1'b1, 1'b1, 48'hFFFF_FFFF_F200);
        push_frame(1'b1, 1'b0, 48'hFFFF_FFFF_F3F4);
        push_frame(1'b1, 1'b1, 48'hFFFF_FFFF_F100);
        push_frame(1'b1, 1'b0, 48'hFFFF_FFFF_F5E8);
        push_frame(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
        push_frame(1'b0, 1'b1, 48'd0);
        drain();

        target = frames_made;
        for (int k = 0; k < 6; k++)
        begin
            apb_write(css_pkg::REG_ARM_ABSENCE, arm_set[k]);
            apb_write(css_pkg::REG_STOP_DELAY, delay_set[k]);
            @(posedge clk);
            calm = (k == 3);
            target += 160;
            while (frames_made < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_frame($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                               css_pkg::field_time_t'({$urandom(), $urandom()}));
                else
                    push_session();
            end
            if (k == 2)
                stalls_asked++;
            drain();
        end
        calm = 1'b0;

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
